// ----- src/rst_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the randomized set table: field widths, command and status codes.
// No dependencies.
package rst_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int RAND_W  = 16;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PICK   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE              = 2'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT_OR_ABSENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL              = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY             = 2'd3;

endpackage

// ----- src/rst_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands in and results out.
// Depends on rst_pkg for field widths.
interface rst_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [rst_pkg::CMD_W-1:0]          command;
    logic signed [rst_pkg::VALUE_W-1:0] value;
    logic [rst_pkg::RAND_W-1:0]         random_word;

    modport source (output valid, command, value, random_word, input ready);
    modport sink   (input valid, command, value, random_word, output ready);
endinterface

interface rst_res_if;
    logic                               valid;
    logic                               ready;
    logic                               success;
    logic [rst_pkg::STAT_W-1:0]         status;
    logic signed [rst_pkg::VALUE_W-1:0] picked_value;
    logic [rst_pkg::COUNT_W-1:0]        member_count;

    modport source (output valid, success, status, picked_value, member_count, input ready);
    modport sink   (input valid, success, status, picked_value, member_count, output ready);
endinterface

// ----- src/rst_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the member ring: holds one entry, loads its neighbor on shift.
// Depends on rst_pkg for the value width.
module rst_cell (
    input  logic                           i_clk,
    input  logic                           i_shift,
    input  logic [rst_pkg::VALUE_W-1:0]    i_data,
    output logic [rst_pkg::VALUE_W-1:0]    o_data
);

    logic [rst_pkg::VALUE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

// ----- src/rst_mod.sv -----
`timescale 1ns / 1ps
// Restoring remainder unit: random word modulo member count, one dividend bit per cycle.
// Depends on rst_pkg for the random word width.
module rst_mod #(
    parameter int CNT_W = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rst_pkg::RAND_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]            i_divisor,
    output logic                        o_done,
    output logic [CNT_W-1:0]            o_rem
);

    localparam int STEP_W = $clog2(rst_pkg::RAND_W);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_step;
    logic [rst_pkg::RAND_W-1:0]  r_dvd;
    logic [CNT_W-1:0]            r_dvs;
    logic [CNT_W-1:0]            r_rem;
    logic [CNT_W:0]              trial;
    logic [CNT_W:0]              diff;
    logic [CNT_W-1:0]            n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[rst_pkg::RAND_W-1]};
        diff  = trial - {1'b0, r_dvs};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = diff[CNT_W-1:0];
        end else begin
            n_rem = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_step <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_dvd  <= {r_dvd[rst_pkg::RAND_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(rst_pkg::RAND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- src/randomized_set_table_top.sv -----
`timescale 1ns / 1ps
// Top level of the randomized set table: ring of member cells, scan control, remainder unit.
// Depends on rst_pkg, rst_if, rst_cell and rst_mod.
//
//  channel  | dir | payload                                        | transfer
//  ---------+-----+------------------------------------------------+--------------------
//  i_cmd    | in  | command, value, random_word                    | valid & ready
//  o_res    | out | success, status, picked_value, member_count    | valid & ready
//
// Members sit in a ring of CAPACITY cells; a scan rotates the ring once, one entry per
// cycle past a single comparator at the head. Insert does one scan, a successful remove
// a second rotation as well (it drops the last member into the freed slot), a pick runs
// the remainder unit first and then one scan. Commands are taken only while no command
// is in work; the result register holds while o_res is stalled and the next command may
// enter behind it. Synchronous reset empties the set at once.
module randomized_set_table_top #(
    parameter int CAPACITY = rst_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rst_cmd_if.sink       i_cmd,
    rst_res_if.source     o_res
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_SCAN, S_FIX, S_DONE} t_state;

    t_state                          r_state;
    logic [rst_pkg::CMD_W-1:0]       r_cmd;
    logic [rst_pkg::VALUE_W-1:0]     r_val;
    logic [rst_pkg::RAND_W-1:0]      r_rnd;
    logic [CNT_W-1:0]                r_count;
    logic [IDX_W-1:0]                r_k;
    logic                            r_found;
    logic [IDX_W-1:0]                r_pos;
    logic [IDX_W-1:0]                r_idx;
    logic [rst_pkg::VALUE_W-1:0]     r_last;
    logic [rst_pkg::VALUE_W-1:0]     r_pick;
    logic                            r_out_valid;
    logic                            r_success;
    logic [rst_pkg::STAT_W-1:0]      r_status;
    logic [rst_pkg::VALUE_W-1:0]     r_picked;
    logic [rst_pkg::COUNT_W-1:0]     r_mcount;

    logic [rst_pkg::VALUE_W-1:0]     cell_q [CAPACITY];
    logic [rst_pkg::VALUE_W-1:0]     head;
    logic [rst_pkg::VALUE_W-1:0]     tail_in;
    logic                            shift;
    logic [CNT_W-1:0]                k_ext;
    logic                            match;
    logic                            at_last;
    logic                            accept;
    logic                            div_start;
    logic                            div_done;
    logic [CNT_W-1:0]                div_rem;
    logic                            out_free;
    logic                            res_ok;
    logic [rst_pkg::STAT_W-1:0]      res_st;
    logic [CNT_W-1:0]                res_cnt;
    logic [CNT_W+rst_pkg::COUNT_W-1:0] cnt_wide;

    // ring: cell i loads cell i+1, the tail loads the head (or a replacement)
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == CAPACITY - 1) begin : g_tail
                rst_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (shift),
                    .i_data  (tail_in),
                    .o_data  (cell_q[gi])
                );
            end else begin : g_body
                rst_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (shift),
                    .i_data  (cell_q[gi+1]),
                    .o_data  (cell_q[gi])
                );
            end
        end
    endgenerate

    rst_mod #(
        .CNT_W (CNT_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign head      = cell_q[0];
    assign shift     = (r_state == S_SCAN) || (r_state == S_FIX);
    assign k_ext     = CNT_W'(r_k);
    assign at_last   = (r_k == IDX_W'(CAPACITY - 1));
    assign match     = (r_state == S_SCAN) && (k_ext < r_count) && (head == r_val);
    assign accept    = i_cmd.valid && i_cmd.ready;
    assign out_free  = !r_out_valid || o_res.ready;

    // remainder unit starts the cycle after the command is latched
    assign div_start = (r_state == S_DIV) && !div_done && (r_k == '0) && !r_found;

    always_comb begin
        tail_in = head;
        if ((r_state == S_SCAN) && (r_cmd == rst_pkg::CMD_INSERT)
                && (k_ext == r_count) && !r_found) begin
            tail_in = r_val;
        end else if ((r_state == S_FIX) && (r_k == r_pos)) begin
            tail_in = r_last;
        end
    end

    always_comb begin
        res_ok  = 1'b0;
        res_st  = rst_pkg::ST_DONE;
        res_cnt = r_count;
        case (r_cmd)
            rst_pkg::CMD_INSERT: begin
                if (r_found) begin
                    res_st = rst_pkg::ST_PRESENT_OR_ABSENT;
                end else if (r_count >= CNT_W'(CAPACITY)) begin
                    res_st = rst_pkg::ST_FULL;
                end else begin
                    res_ok  = 1'b1;
                    res_cnt = r_count + 1'b1;
                end
            end
            rst_pkg::CMD_REMOVE: begin
                if (r_count == '0) begin
                    res_st = rst_pkg::ST_EMPTY;
                end else if (!r_found) begin
                    res_st = rst_pkg::ST_PRESENT_OR_ABSENT;
                end else begin
                    res_ok  = 1'b1;
                    res_cnt = r_count - 1'b1;
                end
            end
            rst_pkg::CMD_PICK: begin
                if (r_count == '0) begin
                    res_st = rst_pkg::ST_EMPTY;
                end else begin
                    res_ok = 1'b1;
                end
            end
            default: begin
                res_ok = 1'b0;
            end
        endcase
    end

    assign cnt_wide = {{rst_pkg::COUNT_W{1'b0}}, res_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_k         <= '0;
        end else begin
            if (r_out_valid && o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_cmd.command;
                        r_val   <= i_cmd.value;
                        r_rnd   <= i_cmd.random_word;
                        r_found <= 1'b0;
                        r_k     <= '0;
                        if ((i_cmd.command == rst_pkg::CMD_PICK) && (r_count != '0)) begin
                            r_state <= S_DIV;
                        end else if ((i_cmd.command == rst_pkg::CMD_INSERT)
                                || (i_cmd.command == rst_pkg::CMD_REMOVE)) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    // mark the start as issued so it fires once
                    if (div_done) begin
                        r_idx   <= div_rem[IDX_W-1:0];
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_found <= 1'b1;
                    end
                end
                S_SCAN: begin
                    r_k <= at_last ? '0 : r_k + 1'b1;
                    if (match && !r_found) begin
                        r_found <= 1'b1;
                        r_pos   <= r_k;
                    end
                    if ((k_ext + CNT_W'(1)) == r_count) begin
                        r_last <= head;
                    end
                    if (r_k == r_idx) begin
                        r_pick <= head;
                    end
                    if (at_last) begin
                        if ((r_cmd == rst_pkg::CMD_REMOVE) && (r_found || match)) begin
                            r_state <= S_FIX;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_FIX: begin
                    r_k <= at_last ? '0 : r_k + 1'b1;
                    if (at_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_success   <= res_ok;
                        r_status    <= res_st;
                        r_picked    <= (res_ok && (r_cmd == rst_pkg::CMD_PICK)) ? r_pick : '0;
                        r_mcount    <= cnt_wide[rst_pkg::COUNT_W-1:0];
                        r_count     <= res_cnt;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.success      = r_success;
    assign o_res.status       = r_status;
    assign o_res.picked_value = r_picked;
    assign o_res.member_count = r_mcount;

endmodule
